### hw/rtl/stpf_pkg.sv
// Package for the spectrum peak finder: word types, widths, scale constants
// and configuration register indices.
// No dependencies; every RTL file of the block refers to it by scoped names.
`default_nettype none

package stpf_pkg;

    localparam int AMP_W      = 16;
    localparam int MAX_BINS   = 4096;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int KEEP_PEAKS = 5;
    localparam int CNT_W      = $clog2(KEEP_PEAKS + 1);
    localparam int IDX_W      = (KEEP_PEAKS > 1) ? $clog2(KEEP_PEAKS) : 1;

    // Scale arithmetic runs two bits wider than an amplitude.
    localparam int SCALE_W = AMP_W + 2;
    // Threshold products: (level - low) << 10 against 717 * (high - low).
    localparam int THR_SHIFT = 10;
    localparam int THR_NUM_W = 11;
    localparam int PROD_W    = AMP_W + 1 + THR_SHIFT + 1;
    localparam logic signed [THR_NUM_W-1:0] THR_NUM = 11'sd717;

    // Autoscale margins in Q.4 dB: 10 dB below the minimum, 5 dB above the maximum.
    localparam logic signed [SCALE_W-1:0] LOW_MARGIN  = 18'sd160;
    localparam logic signed [SCALE_W-1:0] HIGH_MARGIN = 18'sd80;
    localparam logic signed [SCALE_W-1:0] FRAC_MASK   = 18'sd15;

    localparam logic signed [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic signed [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};

    localparam logic                    AUTOSCALE_RESET  = 1'b1;
    localparam logic signed [AMP_W-1:0] FIXED_LOW_RESET  = -16'sd1600;
    localparam logic signed [AMP_W-1:0] FIXED_HIGH_RESET = 16'sd0;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_AUTOSCALE  = 2'd0,
        REG_FIXED_LOW  = 2'd1,
        REG_FIXED_HIGH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [AMP_W-1:0] amplitude;
        logic                    frame_last;
    } sample_t;

    typedef struct packed {
        logic                    peak_valid;
        logic [BIN_W-1:0]        peak_bin;
        logic signed [AMP_W-1:0] peak_level;
        logic signed [AMP_W-1:0] scale_low;
        logic signed [AMP_W-1:0] scale_high;
        logic                    result_last;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/spectrum_top_peak_finder.sv
// Top level of the spectrum peak finder: bin intake, top-N peak list, scale
// and threshold, and the result sequencer, with the APB register bank.
// Depends on stpf_pkg for types and constants.
//
//   Channel   Direction  Handshake                 Word
//   sample    in         sample_valid/ready        stpf_pkg::sample_t, one bin
//   result    out        result_valid/ready        stpf_pkg::result_t, one peak
//   apb       in/out     psel/penable/pready       32-bit register access
//
// One bin is taken in every cycle. A bin passes through an input register,
// updates the running minimum, maximum and peak list in the next cycle, and a
// frame's last bin hands the finished list and scale to a snapshot register.
// The threshold test runs between the snapshot and the result sequencer,
// which then presents one peak per ready cycle (one to five words per frame).
// Bins stall only when a frame ends while both the snapshot and the sequencer
// still hold earlier frames, so frames shorter than the result run slow down.
// Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none

module spectrum_top_peak_finder
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    input  wire stpf_pkg::sample_t                    sample,

    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output stpf_pkg::result_t                         result,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [stpf_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [stpf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [stpf_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    localparam int AW = stpf_pkg::AMP_W;
    localparam int BW = stpf_pkg::BIN_W;
    localparam int KP = stpf_pkg::KEEP_PEAKS;
    localparam int CW = stpf_pkg::CNT_W;
    localparam int IW = stpf_pkg::IDX_W;
    localparam int SW = stpf_pkg::SCALE_W;
    localparam int PW = stpf_pkg::PROD_W;
    localparam logic [BW-1:0] BIN_SAT = BW'(stpf_pkg::MAX_BINS - 1);

    // ------------------------------------------------------------------
    // Configuration registers. Only the word index of the address is decoded.
    // ------------------------------------------------------------------
    logic                 autoscale_reg;
    logic signed [AW-1:0] fixed_low_reg;
    logic signed [AW-1:0] fixed_high_reg;
    logic                 cfg_write;
    stpf_pkg::cfg_reg_t   cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = stpf_pkg::cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            autoscale_reg  <= stpf_pkg::AUTOSCALE_RESET;
            fixed_low_reg  <= stpf_pkg::FIXED_LOW_RESET;
            fixed_high_reg <= stpf_pkg::FIXED_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                stpf_pkg::REG_AUTOSCALE:  autoscale_reg  <= pwdata[0];
                stpf_pkg::REG_FIXED_LOW:  fixed_low_reg  <= pwdata[AW-1:0];
                stpf_pkg::REG_FIXED_HIGH: fixed_high_reg <= pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            stpf_pkg::REG_AUTOSCALE:  prdata = {{(stpf_pkg::APB_DATA_W-1){1'b0}}, autoscale_reg};
            stpf_pkg::REG_FIXED_LOW:  prdata = stpf_pkg::APB_DATA_W'(fixed_low_reg);
            stpf_pkg::REG_FIXED_HIGH: prdata = stpf_pkg::APB_DATA_W'(fixed_high_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves on when the one after it is free
    // or emptying in the same cycle.
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    logic signed [AW-1:0] in_amp_reg;
    logic                 in_last_reg;

    logic                 snap_valid_reg;
    logic                 emit_valid_reg;
    logic [CW-1:0]        emit_count_reg;
    logic [IW-1:0]        emit_idx_reg;

    logic emit_final;
    logic emit_free;
    logic snap_free;
    logic in_fire;

    assign emit_final = (emit_count_reg == '0)
                     || ((CW'(emit_idx_reg) + CW'(1)) == emit_count_reg);
    assign emit_free  = !emit_valid_reg || (result_ready && emit_final);
    assign snap_free  = !snap_valid_reg || emit_free;
    assign in_fire    = in_valid_reg && (!in_last_reg || snap_free);
    assign sample_ready = !in_valid_reg || in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            in_amp_reg  <= sample.amplitude;
            in_last_reg <= sample.frame_last;
        end
    end

    // ------------------------------------------------------------------
    // Frame state: bin counter, neighbour samples, running extremes and the
    // sorted list of the strongest peaks so far.
    // ------------------------------------------------------------------
    logic [BW-1:0]        bin_count_reg;
    logic signed [AW-1:0] older_reg;
    logic signed [AW-1:0] prev_reg;
    logic signed [AW-1:0] min_reg;
    logic signed [AW-1:0] max_reg;
    logic signed [AW-1:0] best_level_reg [KP];
    logic [BW-1:0]        best_bin_reg   [KP];
    logic [CW-1:0]        best_count_reg;

    logic signed [AW-1:0] min_next;
    logic signed [AW-1:0] max_next;
    logic [BW-1:0]        bin_count_next;
    logic                 peak_hit;
    logic [BW-1:0]        peak_bin;
    logic [KP-1:0]        ranks_above;
    logic                 do_insert;
    logic signed [AW-1:0] best_level_next [KP];
    logic [BW-1:0]        best_bin_next   [KP];
    logic [CW-1:0]        best_count_next;

    assign min_next = (in_amp_reg < min_reg) ? in_amp_reg : min_reg;
    assign max_next = (in_amp_reg > max_reg) ? in_amp_reg : max_reg;
    assign bin_count_next = (bin_count_reg == BIN_SAT) ? bin_count_reg
                                                       : bin_count_reg + BW'(1);

    // The previous bin is a peak when it stands strictly above both neighbours.
    assign peak_hit = (bin_count_reg >= BW'(2)) && (prev_reg > older_reg)
                   && (prev_reg > in_amp_reg);
    assign peak_bin = bin_count_reg - BW'(1);

    // Entries that rank at or above the new peak form a prefix of the list,
    // since equal levels keep the earlier bin first.
    always_comb
    begin
        for (int i = 0; i < KP; i++)
        begin
            ranks_above[i] = (CW'(i) < best_count_reg) && (best_level_reg[i] >= prev_reg);
        end
    end

    assign do_insert = peak_hit && !ranks_above[KP-1];

    always_comb
    begin
        for (int i = 0; i < KP; i++)
        begin
            best_level_next[i] = best_level_reg[i];
            best_bin_next[i]   = best_bin_reg[i];
        end
        if (do_insert)
        begin
            if (!ranks_above[0])
            begin
                best_level_next[0] = prev_reg;
                best_bin_next[0]   = peak_bin;
            end
            for (int i = 1; i < KP; i++)
            begin
                if (!ranks_above[i])
                begin
                    if (ranks_above[i-1])
                    begin
                        best_level_next[i] = prev_reg;
                        best_bin_next[i]   = peak_bin;
                    end
                    else
                    begin
                        best_level_next[i] = best_level_reg[i-1];
                        best_bin_next[i]   = best_bin_reg[i-1];
                    end
                end
            end
        end
    end

    assign best_count_next = (do_insert && (best_count_reg != CW'(KP)))
                           ? best_count_reg + CW'(1) : best_count_reg;

    // At the end of a frame everything returns to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg  <= '0;
            older_reg      <= '0;
            prev_reg       <= '0;
            min_reg        <= stpf_pkg::AMP_MAX;
            max_reg        <= stpf_pkg::AMP_MIN;
            best_count_reg <= '0;
        end
        else if (in_fire)
        begin
            if (in_last_reg)
            begin
                bin_count_reg  <= '0;
                older_reg      <= '0;
                prev_reg       <= '0;
                min_reg        <= stpf_pkg::AMP_MAX;
                max_reg        <= stpf_pkg::AMP_MIN;
                best_count_reg <= '0;
            end
            else
            begin
                bin_count_reg  <= bin_count_next;
                older_reg      <= prev_reg;
                prev_reg       <= in_amp_reg;
                min_reg        <= min_next;
                max_reg        <= max_next;
                best_count_reg <= best_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < KP; i++)
            begin
                best_level_reg[i] <= best_level_next[i];
                best_bin_reg[i]   <= best_bin_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale for the ending frame: whole-dB floor and ceiling with margins,
    // saturated to the amplitude range, or the fixed registers.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] low_wide;
    logic signed [SW-1:0] high_wide;
    logic signed [SW-1:0] low_round;
    logic signed [SW-1:0] high_round;
    logic signed [AW-1:0] scale_low;
    logic signed [AW-1:0] scale_high;

    always_comb
    begin
        low_wide   = SW'(min_next) - stpf_pkg::LOW_MARGIN;
        high_wide  = SW'(max_next) + stpf_pkg::HIGH_MARGIN + stpf_pkg::FRAC_MASK;
        low_round  = low_wide & ~stpf_pkg::FRAC_MASK;
        high_round = high_wide & ~stpf_pkg::FRAC_MASK;
        if (!autoscale_reg)
        begin
            scale_low  = fixed_low_reg;
            scale_high = fixed_high_reg;
        end
        else
        begin
            if (low_round < SW'(stpf_pkg::AMP_MIN))
            begin
                scale_low = stpf_pkg::AMP_MIN;
            end
            else
            begin
                scale_low = low_round[AW-1:0];
            end
            if (high_round > SW'(stpf_pkg::AMP_MAX))
            begin
                scale_high = stpf_pkg::AMP_MAX;
            end
            else
            begin
                scale_high = high_round[AW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Snapshot of the finished frame.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] snap_level_reg [KP];
    logic [BW-1:0]        snap_bin_reg   [KP];
    logic [CW-1:0]        snap_count_reg;
    logic signed [AW-1:0] snap_low_reg;
    logic signed [AW-1:0] snap_high_reg;
    logic                 snap_load;

    assign snap_load = in_fire && in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_free)
        begin
            snap_valid_reg <= snap_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            for (int i = 0; i < KP; i++)
            begin
                snap_level_reg[i] <= best_level_next[i];
                snap_bin_reg[i]   <= best_bin_next[i];
            end
            snap_count_reg <= best_count_next;
            snap_low_reg   <= scale_low;
            snap_high_reg  <= scale_high;
        end
    end

    // ------------------------------------------------------------------
    // Threshold: 1024*(level - low) > 717*(high - low), exact. The list is
    // sorted, so the emitted run is the leading stretch of passing entries.
    // ------------------------------------------------------------------
    logic signed [AW:0]   span;
    logic signed [PW-1:0] span_scaled;
    logic signed [AW:0]   rise [KP];
    logic [KP-1:0]        passes;
    logic [CW-1:0]        run_count;
    logic                 run_open;

    assign span        = (AW+1)'(snap_high_reg) - (AW+1)'(snap_low_reg);
    assign span_scaled = PW'(span) * PW'(stpf_pkg::THR_NUM);

    always_comb
    begin
        run_open  = 1'b1;
        run_count = '0;
        for (int i = 0; i < KP; i++)
        begin
            rise[i]   = (AW+1)'(snap_level_reg[i]) - (AW+1)'(snap_low_reg);
            passes[i] = (CW'(i) < snap_count_reg)
                     && ((PW'(rise[i]) <<< stpf_pkg::THR_SHIFT) > span_scaled);
            run_open  = run_open && passes[i];
            if (run_open)
            begin
                run_count = CW'(i + 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sequencer: one word per ready cycle, strongest first; a frame with no
    // passing peak gives a single word with peak_valid low.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] emit_level_reg [KP];
    logic [BW-1:0]        emit_bin_reg   [KP];
    logic signed [AW-1:0] emit_low_reg;
    logic signed [AW-1:0] emit_high_reg;
    logic                 emit_load;

    assign emit_load = snap_valid_reg && emit_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_valid_reg <= 1'b0;
            emit_count_reg <= '0;
            emit_idx_reg   <= '0;
        end
        else if (emit_free)
        begin
            emit_valid_reg <= snap_valid_reg;
            emit_count_reg <= run_count;
            emit_idx_reg   <= '0;
        end
        else if (result_ready)
        begin
            emit_idx_reg <= emit_idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            for (int i = 0; i < KP; i++)
            begin
                emit_level_reg[i] <= snap_level_reg[i];
                emit_bin_reg[i]   <= snap_bin_reg[i];
            end
            emit_low_reg  <= snap_low_reg;
            emit_high_reg <= snap_high_reg;
        end
    end

    always_comb
    begin
        result.peak_valid  = (emit_count_reg != '0);
        result.peak_bin    = result.peak_valid ? emit_bin_reg[emit_idx_reg] : '0;
        result.peak_level  = result.peak_valid ? emit_level_reg[emit_idx_reg] : '0;
        result.scale_low   = emit_low_reg;
        result.scale_high  = emit_high_reg;
        result.result_last = emit_final;
    end

    assign result_valid = emit_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_list_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        best_count_reg <= CW'(KP))
        else $error("peak list count beyond its depth");

    a_emit_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_valid_reg && (emit_count_reg != '0)) |-> (CW'(emit_idx_reg) < emit_count_reg))
        else $error("result index beyond the emitted run");

    a_empty_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.peak_valid) |-> result.result_last)
        else $error("frame without peaks must give a single word");

    a_frame_end_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> snap_valid_reg)
        else $error("frame end did not reach the snapshot");

    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> (best_count_reg == '0) && (bin_count_reg == '0))
        else $error("frame state not cleared after the last bin");

endmodule

`default_nettype wire

### dv/spectrum_top_peak_finder_tb.sv
// Self-checking testbench for spectrum_top_peak_finder: streams frames of bins
// with random idling on both channels, predicts every peak word and checks it.
// Depends on stpf_pkg and the block's RTL only.
`default_nettype none

module spectrum_top_peak_finder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int IDLE_PCT      = 9;      // chance of an idle cycle per side, in percent
    localparam int SETTLE_CYCLES = 16;     // well beyond the pipeline depth
    localparam int CYCLE_LIMIT   = 20000;  // many times the slowest correct run

    // ------------------------------------------------------------------
    // Clock, reset and the signals driven into the block. Every input has a
    // known value from time zero.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                sample_valid = 1'b0;
    logic                                sample_ready;
    stpf_pkg::sample_t                   sample       = '0;
    logic                                result_valid;
    logic                                result_ready = 1'b0;
    stpf_pkg::result_t                   result;
    logic                                psel         = 1'b0;
    logic                                penable      = 1'b0;
    logic                                pwrite       = 1'b0;
    logic [stpf_pkg::APB_ADDR_W-1:0]     paddr        = '0;
    logic [stpf_pkg::APB_DATA_W-1:0]     pwdata       = '0;
    logic [stpf_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;

    always #(CLK_PERIOD / 2) clk = ~clk;

    spectrum_top_peak_finder i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------
    // Bookkeeping. Bins wait in bins_to_send until the driver presents them;
    // peak words predicted from accepted bins wait in peaks_due until the
    // block delivers them, oldest first.
    // ------------------------------------------------------------------
    stpf_pkg::sample_t bins_to_send[$];
    stpf_pkg::result_t peaks_due[$];

    bit calm        = 1'b0; // when set, neither side idles
    bit sample_took = 1'b0; // a bin word was accepted at the last rising edge
    int errors      = 0;
    int cycles      = 0;
    int bins_queued = 0;
    int bins_taken  = 0;
    int frames_sent = 0;
    int words_checked = 0;

    // Shadow copy of the register bank.
    bit autoscale_on = stpf_pkg::AUTOSCALE_RESET;
    int fixed_low    = int'(stpf_pkg::FIXED_LOW_RESET);
    int fixed_high   = int'(stpf_pkg::FIXED_HIGH_RESET);

    // Predictor state for the frame in progress.
    int pos_in_frame = 0;
    int two_back     = 0;
    int one_back     = 0;
    int frame_min    = 32767;
    int frame_max    = -32768;
    int rank_level[stpf_pkg::KEEP_PEAKS];
    int rank_bin[stpf_pkg::KEEP_PEAKS];
    int ranked       = 0;

    function automatic int clamp_amp(int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    // Advances the predicted frame state by one accepted bin. On the last bin
    // of a frame the scale is formed, the ranked peaks are filtered by the
    // threshold and the resulting words are appended to peaks_due.
    function automatic void track_bin(stpf_pkg::sample_t s);
        int amp;
        int slot;
        int k;
        int lo;
        int hi;
        int n;
        stpf_pkg::result_t r;
        amp = int'($signed(s.amplitude));
        if (amp < frame_min)
        begin
            frame_min = amp;
        end
        if (amp > frame_max)
        begin
            frame_max = amp;
        end

        // The previous bin is a peak when it stands strictly above both of
        // its neighbours. Equal levels keep their order of arrival, so an
        // earlier bin outranks a later one of the same level.
        if (pos_in_frame >= 2 && one_back > two_back && one_back > amp)
        begin
            slot = 0;
            while (slot < ranked && rank_level[slot] >= one_back)
            begin
                slot++;
            end
            if (slot < stpf_pkg::KEEP_PEAKS)
            begin
                k = (ranked < stpf_pkg::KEEP_PEAKS) ? ranked : stpf_pkg::KEEP_PEAKS - 1;
                while (k > slot)
                begin
                    rank_level[k] = rank_level[k - 1];
                    rank_bin[k]   = rank_bin[k - 1];
                    k--;
                end
                rank_level[slot] = one_back;
                rank_bin[slot]   = pos_in_frame - 1;
                if (ranked < stpf_pkg::KEEP_PEAKS)
                begin
                    ranked++;
                end
            end
        end
        two_back = one_back;
        one_back = amp;
        // The bin index sticks at its top value in an overlong frame.
        if (pos_in_frame < stpf_pkg::MAX_BINS - 1)
        begin
            pos_in_frame++;
        end

        if (s.frame_last)
        begin
            if (autoscale_on)
            begin
                // Whole-dB floor of min - 10 dB and ceiling of max + 5 dB.
                lo = clamp_amp((frame_min - 160) >>> 4 <<< 4);
                hi = clamp_amp(-((-(frame_max + 80)) >>> 4 <<< 4));
            end
            else
            begin
                lo = fixed_low;
                hi = fixed_high;
            end
            n = 0;
            while (n < ranked && longint'(1024) * (rank_level[n] - lo)
                                 > longint'(717) * (hi - lo))
            begin
                n++;
            end
            r            = '0;
            r.scale_low  = lo[stpf_pkg::AMP_W-1:0];
            r.scale_high = hi[stpf_pkg::AMP_W-1:0];
            if (n == 0)
            begin
                r.result_last = 1'b1;
                peaks_due.insert(peaks_due.size(), r);
            end
            for (k = 0; k < n; k++)
            begin
                r.peak_valid  = 1'b1;
                r.peak_bin    = rank_bin[k][stpf_pkg::BIN_W-1:0];
                r.peak_level  = rank_level[k][stpf_pkg::AMP_W-1:0];
                r.result_last = (k == n - 1);
                peaks_due.insert(peaks_due.size(), r);
            end
            pos_in_frame = 0;
            two_back     = 0;
            one_back     = 0;
            frame_min    = 32767;
            frame_max    = -32768;
            ranked       = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: all inputs change on the falling edge. A bin word stays on the
    // bus unchanged until it has been accepted; the next one may follow at
    // once, so valid is only ever assigned once per falling edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            result_ready <= 1'b0;
        end
        else
        begin
            if (!sample_valid || sample_took)
            begin
                if (bins_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    sample       <= bins_to_send.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
            result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes are sampled on the rising edge. Accepted bins
    // feed the predictor and every delivered peak word is checked field by
    // field against the oldest prediction. The cycle counter guards the run.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stpf_pkg::result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycles, peaks_due.size());
            $display("TB_ERROR");
            $finish;
        end
        else if (!rst_n)
        begin
            sample_took = 1'b0;
        end
        else
        begin
            sample_took = sample_valid && sample_ready;
            if (sample_took)
            begin
                bins_taken++;
                track_bin(sample);
            end
            if (result_valid && result_ready)
            begin
                if (peaks_due.size() == 0)
                begin
                    $error("Unexpected peak word: bin %0d level %0d", result.peak_bin,
                           $signed(result.peak_level));
                    errors++;
                end
                else
                begin
                    want = peaks_due.pop_front();
                    words_checked++;
                    if (result.peak_valid !== want.peak_valid)
                    begin
                        $error("peak_valid: expected %0d, got %0d",
                               want.peak_valid, result.peak_valid);
                        errors++;
                    end
                    if (result.peak_bin !== want.peak_bin)
                    begin
                        $error("peak_bin: expected %0d, got %0d",
                               want.peak_bin, result.peak_bin);
                        errors++;
                    end
                    if (result.peak_level !== want.peak_level)
                    begin
                        $error("peak_level: expected %0d, got %0d",
                               $signed(want.peak_level), $signed(result.peak_level));
                        errors++;
                    end
                    if (result.scale_low !== want.scale_low)
                    begin
                        $error("scale_low: expected %0d, got %0d",
                               $signed(want.scale_low), $signed(result.scale_low));
                        errors++;
                    end
                    if (result.scale_high !== want.scale_high)
                    begin
                        $error("scale_high: expected %0d, got %0d",
                               $signed(want.scale_high), $signed(result.scale_high));
                        errors++;
                    end
                    if (result.result_last !== want.result_last)
                    begin
                        $error("result_last: expected %0d, got %0d",
                               want.result_last, result.result_last);
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register access. A transfer has a setup and an access cycle; pready is
    // honoured even though the block always holds it high.
    // ------------------------------------------------------------------
    task automatic apb_xfer(input bit wr, input stpf_pkg::cfg_reg_t idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= stpf_pkg::APB_ADDR_W'(idx) << 2;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads a register back and compares it with the shadow copy.
    task automatic check_reg(input stpf_pkg::cfg_reg_t idx);
        logic [31:0] got;
        logic [31:0] want;
        logic [31:0] mask;
        mask = (idx == stpf_pkg::REG_AUTOSCALE) ? 32'h1 : 32'hFFFF;
        case (idx)
            stpf_pkg::REG_AUTOSCALE: want = 32'(autoscale_on);
            stpf_pkg::REG_FIXED_LOW: want = 32'(fixed_low);
            default:                 want = 32'(fixed_high);
        endcase
        apb_xfer(1'b0, idx, '0, got);
        if ((got & mask) !== (want & mask))
        begin
            $error("%s read back: expected %0h, got %0h", idx.name(), want & mask, got & mask);
            errors++;
        end
    endtask

    task automatic set_reg(input stpf_pkg::cfg_reg_t idx, input int value);
        logic [31:0] unused;
        apb_xfer(1'b1, idx, 32'(value), unused);
        case (idx)
            stpf_pkg::REG_AUTOSCALE: autoscale_on = value[0];
            stpf_pkg::REG_FIXED_LOW: fixed_low    = int'($signed(value[15:0]));
            default:                 fixed_high   = int'($signed(value[15:0]));
        endcase
        check_reg(idx);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_bin(input int amp, input bit last);
        stpf_pkg::sample_t s;
        s.amplitude  = amp[stpf_pkg::AMP_W-1:0];
        s.frame_last = last;
        bins_to_send.insert(bins_to_send.size(), s);
        bins_queued++;
        if (last)
        begin
            frames_sent++;
        end
    endtask

    // One frame of random length and shape. Most frames are long enough to
    // hold peaks; a few are the one- and two-bin frames that never can.
    // Narrow-range content gives plenty of equal levels and plateaus, wide
    // content exercises every amplitude bit and the saturating scale.
    task automatic queue_random_frame();
        int len;
        int pick;
        int style;
        int base;
        int amp;
        pick  = $urandom_range(0, 99);
        style = $urandom_range(0, 2);
        base  = int'($urandom_range(0, 2000)) - 1600;
        if (pick < 15)
        begin
            len = $urandom_range(1, 2);
        end
        else if (pick < 85)
        begin
            len = $urandom_range(3, 12);
        end
        else
        begin
            len = $urandom_range(13, 40);
        end
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0:       amp = int'($signed(16'($urandom)));
                1:       amp = base + int'($urandom_range(0, 12));
                default: amp = base + int'($urandom_range(0, 600)) - 300;
            endcase
            queue_bin(amp, i == len - 1);
        end
    endtask

    task automatic queue_random_bins(input int count);
        int stop;
        stop = bins_queued + count;
        while (bins_queued < stop)
        begin
            queue_random_frame();
        end
    endtask

    // Waits until every queued bin has gone in and every predicted word has
    // come out, then lets the pipeline settle so that the block is idle.
    task automatic drain();
        while (bins_to_send.size() != 0 || sample_valid)
        begin
            @(posedge clk);
        end
        while (peaks_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register values after reset.
        check_reg(stpf_pkg::REG_AUTOSCALE);
        check_reg(stpf_pkg::REG_FIXED_LOW);
        check_reg(stpf_pkg::REG_FIXED_HIGH);

        // Directed frames under the reset scale (autoscale on).
        // A one-bin frame at the most negative level and a two-bin frame:
        // neither can hold a peak, so each yields a single empty word.
        queue_bin(-32768, 1'b1);
        queue_bin(32767, 1'b0);
        queue_bin(5, 1'b1);
        // Shortest frame with a peak, at both amplitude extremes, where both
        // ends of the derived scale saturate.
        queue_bin(0, 1'b0);
        queue_bin(32767, 1'b0);
        queue_bin(-32768, 1'b1);
        // Seven peaks, two of them level: only five are kept and the earlier
        // of the equal pair ranks first.
        queue_bin(-1000, 1'b0);
        queue_bin(400, 1'b0);
        queue_bin(0, 1'b0);
        queue_bin(400, 1'b0);
        queue_bin(0, 1'b0);
        queue_bin(300, 1'b0);
        queue_bin(0, 1'b0);
        queue_bin(500, 1'b0);
        queue_bin(0, 1'b0);
        queue_bin(200, 1'b0);
        queue_bin(0, 1'b0);
        queue_bin(600, 1'b0);
        queue_bin(0, 1'b0);
        queue_bin(450, 1'b0);
        queue_bin(1, 1'b1);
        // A flat top is not a strict maximum.
        queue_bin(0, 1'b0);
        queue_bin(50, 1'b0);
        queue_bin(50, 1'b0);
        queue_bin(0, 1'b1);
        drain();

        // Fixed scale with its reset bounds.
        set_reg(stpf_pkg::REG_AUTOSCALE, 0);
        queue_random_bins(10);
        drain();

        // Widest fixed scale.
        set_reg(stpf_pkg::REG_FIXED_LOW, -32768);
        set_reg(stpf_pkg::REG_FIXED_HIGH, 32767);
        queue_random_bins(10);
        drain();

        // Inverted fixed scale: the threshold falls below the low end, so
        // nearly every kept peak passes.
        set_reg(stpf_pkg::REG_FIXED_LOW, 32767);
        set_reg(stpf_pkg::REG_FIXED_HIGH, -32768);
        queue_random_bins(10);
        drain();

        // Zero-width scale: only levels above zero pass.
        set_reg(stpf_pkg::REG_FIXED_LOW, 0);
        set_reg(stpf_pkg::REG_FIXED_HIGH, 0);
        queue_random_bins(10);
        drain();

        // Random frames with the derived scale and no idling on either side.
        set_reg(stpf_pkg::REG_AUTOSCALE, 1);
        calm = 1'b1;
        queue_random_bins(25);
        drain();
        calm = 1'b0;

        // Random frames against a random fixed scale in the usual dB range.
        set_reg(stpf_pkg::REG_AUTOSCALE, 0);
        set_reg(stpf_pkg::REG_FIXED_LOW, int'($urandom_range(0, 1600)) - 1600);
        set_reg(stpf_pkg::REG_FIXED_HIGH, fixed_low + int'($urandom_range(100, 1600)));
        queue_random_bins(12);
        drain();

        $display("Sent %0d frames (%0d bins) under derived, fixed, inverted and zero-width scales,",
                 frames_sent, bins_taken);
        $display("with one stretch free of idling; %0d peak words checked in %0d cycles.",
                 words_checked, cycles);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/stpf_pkg.sv
hw/rtl/spectrum_top_peak_finder.sv
dv/spectrum_top_peak_finder_tb.sv
